[rtl/assert_macros.svh]
// Assertion macros shared by the event log RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define ELRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every rising clk edge outside reset.
`define ELRB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/elrb_pkg.sv]
// Types, constants and helpers of the event log ring buffer.
package elrb_pkg;

  localparam int LOG_DEPTH   = 16;
  localparam int ENTRY_WIDTH = 64;
  localparam int PTR_W       = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W       = $clog2(LOG_DEPTH + 1);
  localparam int PADDR_W     = 3;

  localparam logic [PADDR_W-1:0] ADDR_LOG_ENABLED = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_LOG_MODE    = 3'd4;

  localparam logic MODE_OVERWRITE = 1'b0;
  localparam logic MODE_DISCARD   = 1'b1;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_DUMP  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_STORED     = 3'd0,
    ST_OVERWROTE  = 3'd1,
    ST_DROPPED    = 3'd2,
    ST_DISABLED   = 3'd3,
    ST_CLEARED    = 3'd4,
    ST_DUMP_ENTRY = 3'd5,
    ST_DUMP_EMPTY = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_DUMP = 2'b10
  } fsm_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] entry_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] entry_out;
    logic [4:0]  entries_held;
    logic [15:0] overflows;
    logic        log_full;
    logic        last;
  } out_item_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == PTR_W'(LOG_DEPTH - 1)) res = '0;
    else res = ptr + PTR_W'(1);
    return res;
  endfunction

endpackage

[rtl/elrb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module elrb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]        wdata,
  input  logic                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/event_log_ring_buffer.sv]
// Top level of the event log ring buffer.
//
// Requests enter on in_valid/in_ready with in_item (req_type, entry_data);
// results leave on out_valid/out_ready with out_item. Add, clear, a dump of
// an empty or disabled log and a disabled add each give one result in the
// cycle after the request is taken. A dump of N entries gives N results,
// oldest first, the first in the cycle after acceptance and then one per
// cycle while the output slot is free, set by the single read port of the
// entry RAM; the next request is taken once the last entry read has been
// issued. Request code 3 is taken and gives no result.
// When the receiver stalls, the output register and the RAM read register
// hold the pending result and no new read or request is taken until it
// leaves. Reset (rst_n, synchronous) empties the log, zeroes the overflow
// count, enables logging in overwrite mode; the entry RAM is not cleared,
// since a dump reads only entries written since the last clear.
// Registers on the APB port: log_enabled at 0x0, log_mode at 0x4.
`include "assert_macros.svh"

module event_log_ring_buffer
  import elrb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  fsm_t             state_r, state_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             full_r, full_nxt;
  logic [15:0]      ovf_r, ovf_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             from_ram_r, from_ram_nxt;
  out_item_t        meta_r, meta_nxt;
  logic             log_enabled_r, log_mode_r;

  logic             slot_free, in_fire, cfg_write;
  logic             emit;
  status_t          emit_status;
  logic             emit_last;
  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_raddr, dump_start;
  logic [ENTRY_WIDTH-1:0] ram_rdata;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_enabled_r <= 1'b1;
      log_mode_r    <= MODE_OVERWRITE;
    end else if (cfg_write) begin
      if (paddr[2] == ADDR_LOG_MODE[2]) log_mode_r <= pwdata[0];
      else log_enabled_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ADDR_LOG_MODE[2]) prdata[0] = log_mode_r;
    else prdata[0] = log_enabled_r;
  end

  // Request handling
  assign slot_free  = !out_valid_r || out_ready;
  assign in_ready   = (state_r == FSM_IDLE) && slot_free;
  assign in_fire    = in_valid && in_ready;
  assign dump_start = full_r ? wp_r : '0;

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    count_nxt     = count_r;
    full_nxt      = full_r;
    ovf_nxt       = ovf_r;
    rd_ptr_nxt    = rd_ptr_r;
    remain_nxt    = remain_r;
    out_valid_nxt = out_valid_r && !out_ready;
    from_ram_nxt  = from_ram_r;
    meta_nxt      = meta_r;
    emit          = 1'b0;
    emit_status   = ST_STORED;
    emit_last     = 1'b1;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = rd_ptr_r;

    if (in_fire) begin
      case (req_t'(in_item.req_type))
        REQ_ADD: begin
          emit = 1'b1;
          if (!log_enabled_r) begin
            emit_status = ST_DISABLED;
          end else if (full_r && log_mode_r == MODE_DISCARD) begin
            if (ovf_r != '1) ovf_nxt = ovf_r + 16'd1;
            emit_status = ST_DROPPED;
          end else begin
            emit_status = full_r ? ST_OVERWROTE : ST_STORED;
            if (full_r && ovf_r != '1) ovf_nxt = ovf_r + 16'd1;
            ram_we = 1'b1;
            wp_nxt = next_ptr(wp_r);
            if (count_r < CNT_W'(LOG_DEPTH)) begin
              count_nxt = count_r + CNT_W'(1);
              full_nxt  = (count_r + CNT_W'(1)) == CNT_W'(LOG_DEPTH);
            end
          end
        end
        REQ_CLEAR: begin
          emit        = 1'b1;
          emit_status = ST_CLEARED;
          wp_nxt      = '0;
          count_nxt   = '0;
          full_nxt    = 1'b0;
          ovf_nxt     = '0;
        end
        REQ_DUMP: begin
          emit = 1'b1;
          if (!log_enabled_r) begin
            emit_status = ST_DISABLED;
          end else if (count_r == '0) begin
            emit_status = ST_DUMP_EMPTY;
          end else begin
            emit_status = ST_DUMP_ENTRY;
            emit_last   = (count_r == CNT_W'(1));
            ram_re      = 1'b1;
            ram_raddr   = dump_start;
            rd_ptr_nxt  = next_ptr(dump_start);
            remain_nxt  = count_r - CNT_W'(1);
            if (count_r != CNT_W'(1)) state_nxt = FSM_DUMP;
          end
        end
        default: begin
        end
      endcase
    end else if (state_r == FSM_DUMP && slot_free) begin
      // one stored entry per cycle while the output slot is free
      emit        = 1'b1;
      emit_status = ST_DUMP_ENTRY;
      emit_last   = (remain_r == CNT_W'(1));
      ram_re      = 1'b1;
      rd_ptr_nxt  = next_ptr(rd_ptr_r);
      remain_nxt  = remain_r - CNT_W'(1);
      if (remain_r == CNT_W'(1)) state_nxt = FSM_IDLE;
    end

    if (emit) begin
      out_valid_nxt         = 1'b1;
      from_ram_nxt          = (emit_status == ST_DUMP_ENTRY);
      meta_nxt.status       = emit_status;
      meta_nxt.entry_out    = '0;
      meta_nxt.entries_held = 5'(count_nxt);
      meta_nxt.overflows    = ovf_nxt;
      meta_nxt.log_full     = full_nxt;
      meta_nxt.last         = emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      wp_r        <= '0;
      count_r     <= '0;
      full_r      <= 1'b0;
      ovf_r       <= '0;
      rd_ptr_r    <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
      from_ram_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      count_r     <= count_nxt;
      full_r      <= full_nxt;
      ovf_r       <= ovf_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
      from_ram_r  <= from_ram_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meta_r <= meta_nxt;
  end

  // Read data register doubles as the entry field of the output slot
  elrb_ram #(
    .WIDTH(ENTRY_WIDTH),
    .DEPTH(LOG_DEPTH)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(in_item.entry_data[ENTRY_WIDTH-1:0]),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    out_item           = meta_r;
    out_item.entry_out = from_ram_r ? 64'(ram_rdata) : 64'd0;
  end

  assign out_valid = out_valid_r;

  `ELRB_ASSERT(a_full_tracks_count, full_r == (count_r == CNT_W'(LOG_DEPTH)), "full flag and count disagree")
  `ELRB_ASSERT(a_count_in_range, count_r <= CNT_W'(LOG_DEPTH), "entry count beyond depth")
  `ELRB_ASSERT_IMPL(a_dump_has_work, state_r == FSM_DUMP, remain_r != '0, "dump state with nothing left")
  `ELRB_ASSERT_IMPL(a_read_into_free_slot, ram_re, slot_free && !ram_we, "RAM read while output slot busy")

endmodule

[tb/sv/tb.sv]
// Testbench for event_log_ring_buffer: random request traffic checked against a ring model.
`timescale 1ns / 1ps

module tb
  import elrb_pkg::*;
();

  localparam int          CLK_PERIOD  = 8;
  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam int          HOLD_CYCLES = 48;
  localparam int          TAIL_ADDS   = 20;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam logic [15:0] OVF_MAX     = 16'hFFFF;

  // Ring model plus the queue of results still owed by the block.
  class log_scoreboard;
    logic [63:0]      entries [LOG_DEPTH];
    logic [PTR_W-1:0] wr_ptr;
    logic [CNT_W-1:0] held;
    logic             full;
    logic [15:0]      ovf;
    logic             enabled;
    logic             mode;
    out_item_t        pending[$];
    int errors, n_results, n_add, n_dump, n_clear, n_ignored, n_fills, n_settings;

    function new();
      wr_ptr  = '0;
      held    = '0;
      full    = 1'b0;
      ovf     = '0;
      enabled = 1'b1;
      mode    = MODE_OVERWRITE;
    endfunction

    function void write_reg(logic [PADDR_W-1:0] addr, logic val);
      if (addr == ADDR_LOG_ENABLED) enabled = val;
      else if (addr == ADDR_LOG_MODE) mode = val;
    endfunction

    function void push(status_t st, logic [63:0] e, logic lst);
      out_item_t r;
      r.status       = st;
      r.entry_out    = e;
      r.entries_held = 5'(held);
      r.overflows    = ovf;
      r.log_full     = full;
      r.last         = lst;
      pending.push_back(r);
    endfunction

    function void bump_ovf();
      if (ovf != OVF_MAX) ovf = ovf + 16'd1;
    endfunction

    function void note_request(in_item_t it);
      status_t st;
      int      idx;
      case (it.req_type)
        REQ_ADD: begin
          n_add++;
          if (!enabled) begin
            push(ST_DISABLED, '0, 1'b1);
          end else if (full && mode == MODE_DISCARD) begin
            bump_ovf();
            push(ST_DROPPED, '0, 1'b1);
          end else begin
            st = ST_STORED;
            if (full) begin
              bump_ovf();
              st = ST_OVERWROTE;
            end
            entries[wr_ptr] = 64'(it.entry_data[ENTRY_WIDTH-1:0]);
            wr_ptr = (wr_ptr == PTR_W'(LOG_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
            if (held < CNT_W'(LOG_DEPTH)) begin
              held = held + CNT_W'(1);
              if (held == CNT_W'(LOG_DEPTH)) begin
                full = 1'b1;
                n_fills++;
              end
            end
            push(st, '0, 1'b1);
          end
        end
        REQ_CLEAR: begin
          n_clear++;
          wr_ptr = '0;
          held   = '0;
          full   = 1'b0;
          ovf    = '0;
          push(ST_CLEARED, '0, 1'b1);
        end
        REQ_DUMP: begin
          n_dump++;
          if (!enabled) begin
            push(ST_DISABLED, '0, 1'b1);
          end else if (held == '0) begin
            push(ST_DUMP_EMPTY, '0, 1'b1);
          end else begin
            // full ring starts at the write pointer, otherwise at slot 0
            idx = full ? int'(wr_ptr) : 0;
            for (int i = 0; i < int'(held); i++) begin
              push(ST_DUMP_ENTRY, entries[idx], i == int'(held) - 1);
              idx = (idx + 1) % LOG_DEPTH;
            end
          end
        end
        default: n_ignored++;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      string     bad;
      n_results++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d with nothing owed: st=%0d entry=%h",
                         n_results, got.status, got.entry_out));
        return;
      end
      want = pending.pop_front();
      bad  = "";
      if (got.status !== want.status)             bad = {bad, " status"};
      if (got.entry_out !== want.entry_out)       bad = {bad, " entry_out"};
      if (got.entries_held !== want.entries_held) bad = {bad, " entries_held"};
      if (got.overflows !== want.overflows)       bad = {bad, " overflows"};
      if (got.log_full !== want.log_full)         bad = {bad, " log_full"};
      if (got.last !== want.last)                 bad = {bad, " last"};
      if (bad != "")
        report($sformatf("result %0d bad%s; exp %0d/%h/%0d/%0d/%0d/%0d got %0d/%h/%0d/%0d/%0d/%0d",
                         n_results, bad,
                         want.status, want.entry_out, want.entries_held,
                         want.overflows, want.log_full, want.last,
                         got.status, got.entry_out, got.entries_held,
                         got.overflows, got.log_full, got.last));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_item;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  log_scoreboard sb = new();
  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_rx_req;
  int cycle_cnt;

  event_log_ring_buffer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // both handshakes sampled with pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_item);
      if (out_valid && out_ready) sb.check_result(out_item);
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : rx_side
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_rx_req) begin
        hold_rx_req = 1'b0;
        stall_left  = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cycle_cnt, sb.pending.size());
    $display("status: fail");
    $finish;
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // valid stays high across back-to-back requests; lowered only for a gap
  task automatic send_req(input logic [1:0] rt, input logic [63:0] d);
    in_item_t it;
    it.req_type   = rt;
    it.entry_data = d;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_results(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    // request code 3 leaves nothing to wait on, so let the pipe settle
    repeat (settle) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic [PADDR_W-1:0] addr, input logic wr,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    if (wr) sb.write_reg(addr, wdata[0]);
  endtask

  // block must be idle; each register written then read back
  task automatic cfg_set(input logic en, input logic mode);
    logic [31:0] rd;
    apb_xfer(ADDR_LOG_ENABLED, 1'b1, {31'b0, en}, rd);
    apb_xfer(ADDR_LOG_ENABLED, 1'b0, '0, rd);
    if (rd !== {31'b0, en}) sb.report($sformatf("log_enabled reads %h", rd));
    apb_xfer(ADDR_LOG_MODE, 1'b1, {31'b0, mode}, rd);
    apb_xfer(ADDR_LOG_MODE, 1'b0, '0, rd);
    if (rd !== {31'b0, mode}) sb.report($sformatf("log_mode reads %h", rd));
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.n_settings++;
  endtask

  // runs of adds closed by a dump, with the odd clear and stray request
  task automatic run_traffic(input int n_items);
    int sent, burst;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 5) == 0) begin
        send_req(REQ_CLEAR, rand_word());
        sent++;
      end
      burst = $urandom_range(1, 22);
      for (int k = 0; k < burst; k++) begin
        if ($urandom_range(0, 24) == 0) send_req(REQ_UNUSED, rand_word());
        if ($urandom_range(0, 11) == 0) send_req(2'($urandom_range(0, 3)), rand_word());
        else send_req(REQ_ADD, rand_word());
        sent++;
      end
      send_req(REQ_DUMP, rand_word());
      sent++;
    end
  endtask

  // receiver holds off while requests keep coming, so the block backs up
  task automatic back_pressure();
    bit saved;
    saved       = tx_idle_en;
    tx_idle_en  = 1'b0;
    hold_rx_req = 1'b1;
    for (int k = 0; k < 10; k++) send_req(REQ_ADD, rand_word());
    send_req(REQ_DUMP, rand_word());
    tx_idle_en = saved;
  endtask

  initial begin : stimulus
    bit en_tab   [6];
    bit mode_tab [6];
    en_tab   = '{1, 1, 0, 1, 0, 1};
    mode_tab = '{0, 1, 1, 1, 0, 0};
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    hold_rx_req = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, on reset settings: empty dump, extreme words, ignored code
    send_req(REQ_DUMP, '0);
    send_req(REQ_ADD, '0);
    send_req(REQ_ADD, '1);
    send_req(REQ_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
    send_req(REQ_ADD, 64'h5555_5555_5555_5555);
    send_req(REQ_DUMP, '1);
    send_req(REQ_UNUSED, '1);
    send_req(REQ_DUMP, '0);
    send_req(REQ_CLEAR, '1);
    send_req(REQ_DUMP, '0);
    wait_results(4);
    // disabled: add and dump refused, clear still acts
    cfg_set(1'b0, MODE_OVERWRITE);
    send_req(REQ_ADD, '1);
    send_req(REQ_DUMP, '0);
    send_req(REQ_ADD, '1);
    send_req(REQ_CLEAR, '0);
    wait_results(4);

    for (int ph = 0; ph < 6; ph++) begin
      cfg_set(en_tab[ph], mode_tab[ph]);
      run_traffic(en_tab[ph] ? 24 : 16);
      if (ph == 0 || ph == 3) back_pressure();
      if (ph == 2) wait_results(0);
      run_traffic(en_tab[ph] ? 24 : 0);
      wait_results(4);
    end

    // last part, no idling: fill past the depth in both full-log modes
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    cfg_set(1'b1, MODE_OVERWRITE);
    send_req(REQ_CLEAR, '0);
    for (int k = 0; k < TAIL_ADDS; k++) send_req(REQ_ADD, rand_word());
    send_req(REQ_DUMP, '0);
    wait_results(4);
    cfg_set(1'b1, MODE_DISCARD);
    for (int k = 0; k < 3; k++) send_req(REQ_ADD, rand_word());
    send_req(REQ_DUMP, '0);
    send_req(REQ_CLEAR, '0);
    send_req(REQ_DUMP, '0);
    wait_results(20);

    $display("covered %0d requests: %0d add, %0d dump, %0d clear, %0d ignored; %0d results",
             sb.n_add + sb.n_dump + sb.n_clear + sb.n_ignored, sb.n_add, sb.n_dump,
             sb.n_clear, sb.n_ignored, sb.n_results);
    $display("log filled %0d times over %0d register settings, overwrite and discard when full",
             sb.n_fills, sb.n_settings);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
